/* rtl/console_line_editor_macros.svh */
// Assertion macros used by the console line editor checker.
`ifndef CONSOLE_LINE_EDITOR_MACROS_SVH
`define CONSOLE_LINE_EDITOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cle_pkg.sv */
// Types, constants and codes shared by the console line editor modules.
package cle_pkg;

  localparam int LINE_BUFFER_SIZE_DEF = 128;
  localparam int READ_INDEX_W         = 7;
  localparam int LINE_LEN_W           = 7;
  localparam int MAX_READ_DEPTH       = 2 ** READ_INDEX_W;

  localparam int ADDR_W               = 3;
  localparam logic REG_ECHO_ENABLE    = 1'b0;

  localparam logic ACT_RECEIVE        = 1'b0;
  localparam logic ACT_READ           = 1'b1;

  localparam logic [1:0] KIND_ECHO    = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  localparam logic [7:0] CH_NUL       = 8'd0;
  localparam logic [7:0] CH_BEL       = 8'd7;
  localparam logic [7:0] CH_BS        = 8'd8;
  localparam logic [7:0] CH_LF        = 8'd10;
  localparam logic [7:0] CH_CR        = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] CH_DEL       = 8'd127;

  typedef struct packed {
    logic                    action;
    logic [7:0]              rx_byte;
    logic [READ_INDEX_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [7:0]            data_byte;
    logic [LINE_LEN_W-1:0] line_length;
    logic                  last;
  } out_item_t;

  // Which result sequence an item produces.
  typedef enum logic [2:0] {
    GRP_CR_ECHO,
    GRP_CR,
    GRP_BS,
    GRP_ECHO,
    GRP_READ
  } grp_t;

  typedef enum logic [1:0] {
    FILL_HOLD,
    FILL_INC,
    FILL_DEC,
    FILL_CLR
  } fill_op_t;

  typedef struct packed {
    grp_t       grp;
    logic       has_result;
    logic       store_wr;
    fill_op_t   fill_op;
    logic [7:0] echo_byte;
  } dec_t;

endpackage

/* rtl/cle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/cle_decode.sv */
// Classifies one item against the current line fill and echo setting.
module cle_decode #(
  parameter int LINE_BUFFER_SIZE = cle_pkg::LINE_BUFFER_SIZE_DEF
) (
  input  cle_pkg::in_item_t                   item,
  input  logic [$clog2(LINE_BUFFER_SIZE)-1:0] fill,
  input  logic                                echo,
  output cle_pkg::dec_t                       dec
);

  localparam int FILL_W = $clog2(LINE_BUFFER_SIZE);

  logic room;
  logic empty;

  assign room  = fill < FILL_W'(LINE_BUFFER_SIZE - 1);
  assign empty = fill == '0;

  always_comb begin
    dec            = '0;
    dec.grp        = cle_pkg::GRP_ECHO;
    dec.fill_op    = cle_pkg::FILL_HOLD;
    dec.echo_byte  = item.rx_byte;
    if (item.action == cle_pkg::ACT_READ) begin
      dec.grp        = cle_pkg::GRP_READ;
      dec.has_result = 1'b1;
    end else begin
      case (item.rx_byte)
        cle_pkg::CH_CR: begin
          dec.grp        = echo ? cle_pkg::GRP_CR_ECHO : cle_pkg::GRP_CR;
          dec.has_result = 1'b1;
          dec.fill_op    = cle_pkg::FILL_CLR;
        end
        cle_pkg::CH_BS, cle_pkg::CH_DEL: begin
          dec.grp = cle_pkg::GRP_BS;
          if (!empty) begin
            dec.fill_op    = cle_pkg::FILL_DEC;
            dec.has_result = echo;
          end
        end
        cle_pkg::CH_LF, cle_pkg::CH_NUL: begin
          dec.has_result = 1'b0;
        end
        default: begin
          dec.has_result = echo;
          if (room) begin
            dec.store_wr = 1'b1;
            dec.fill_op  = cle_pkg::FILL_INC;
          end else begin
            dec.echo_byte = cle_pkg::CH_BEL;
          end
        end
      endcase
    end
  end

endmodule

/* rtl/console_line_editor.sv */
// Top level of the console line editor: item pipeline, line store and APB register.
//
//   Channel | Direction | Handshake        | Payload
//   in_     | input     | in_valid/ready   | in_data  (action, rx_byte, read_index)
//   out_    | output    | out_valid/ready  | out_data (kind, data_byte, line_length, last)
//   APB     | input     | psel/penable     | paddr, pwdata, prdata (echo_enable)
//
// An item is held in the input register, then is decoded and, if it has results,
// loaded into the group register; its results leave through the output register
// one per cycle while out_ready allows. An item has one to three results, or none,
// and all of them leave through the single output port.
// Reset is synchronous and active low; the line store needs no clearing pass because
// a valid bit per entry makes unwritten entries read as zero.
// Stalls on out_ready back up through the group and input registers to in_ready.
module console_line_editor #(
  parameter int LINE_BUFFER_SIZE = cle_pkg::LINE_BUFFER_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  cle_pkg::in_item_t             in_data,

  output logic                          out_valid,
  input  logic                          out_ready,
  output cle_pkg::out_item_t            out_data,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cle_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // Only the first 128 positions can ever be read back, so the store stops there.
  localparam int FILL_W      = $clog2(LINE_BUFFER_SIZE);
  localparam int STORE_DEPTH = (LINE_BUFFER_SIZE < cle_pkg::MAX_READ_DEPTH) ?
                               LINE_BUFFER_SIZE : cle_pkg::MAX_READ_DEPTH;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int LEN_W       = cle_pkg::LINE_LEN_W;
  localparam int IDX_W       = cle_pkg::READ_INDEX_W;

  // Configuration register. The word index is paddr[2]; byte lanes are ignored.
  logic echo_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == cle_pkg::REG_ECHO_ENABLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_r <= 1'b0;
    end else if (cfg_wr) begin
      echo_r <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == cle_pkg::REG_ECHO_ENABLE) begin
      prdata[0] = echo_r;
    end
  end

  // Input register.
  logic              s1_valid_r;
  cle_pkg::in_item_t s1_item_r;
  logic              s1_adv;

  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  // Decode against the live fill count. The fill count moves when the item
  // leaves the input register, so the next item always sees it up to date.
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  cle_pkg::dec_t     dec;

  cle_decode #(
    .LINE_BUFFER_SIZE(LINE_BUFFER_SIZE)
  ) u_decode (
    .item (s1_item_r),
    .fill (fill_r),
    .echo (echo_r),
    .dec  (dec)
  );

  logic s2_valid_r;
  logic s2_free;
  logic s2_done;

  assign s1_adv = s1_valid_r && (!dec.has_result || s2_free);

  always_comb begin
    case (dec.fill_op)
      cle_pkg::FILL_INC: fill_nxt = fill_r + FILL_W'(1);
      cle_pkg::FILL_DEC: fill_nxt = fill_r - FILL_W'(1);
      cle_pkg::FILL_CLR: fill_nxt = '0;
      default:           fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (s1_adv) begin
      fill_r <= fill_nxt;
    end
  end

  // Line store with a valid bit per entry; a never-written entry reads as zero.
  logic [STORE_DEPTH-1:0] valid_r;
  logic                   wr_in_store;
  logic                   ram_we;
  logic                   ram_re;
  logic [STORE_AW-1:0]    ram_waddr;
  logic [STORE_AW-1:0]    ram_raddr;
  logic [7:0]             ram_rdata;
  logic                   idx_in_store;
  logic                   rd_ok;
  logic [IDX_W-1:0]       rd_idx;

  assign wr_in_store  = {1'b0, fill_r} < (FILL_W + 1)'(STORE_DEPTH);
  assign ram_waddr    = fill_r[STORE_AW-1:0];
  assign ram_we       = s1_adv && dec.store_wr && wr_in_store;

  assign rd_idx       = s1_item_r.read_index;
  assign idx_in_store = {1'b0, rd_idx} < (IDX_W + 1)'(STORE_DEPTH);
  assign ram_raddr    = rd_idx[STORE_AW-1:0];
  assign ram_re       = s1_adv && (dec.grp == cle_pkg::GRP_READ);
  assign rd_ok        = idx_in_store && valid_r[ram_raddr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[ram_waddr] <= 1'b1;
    end
  end

  cle_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s1_item_r.rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Group register: holds one item's result sequence while it drains. The
  // store's read data register is only reloaded when a new group enters, so
  // it stays put for as long as the read group waits here.
  cle_pkg::grp_t       s2_grp_r;
  logic [7:0]          s2_byte_r;
  logic [LEN_W-1:0]    s2_len_r;
  logic                s2_rdok_r;
  logic [1:0]          pos_r;
  logic                out_valid_r;
  cle_pkg::out_item_t  out_data_r;
  cle_pkg::out_item_t  res;
  logic                out_load;

  assign out_load = s2_valid_r && (!out_valid_r || out_ready);
  assign s2_done  = out_load && res.last;
  assign s2_free  = !s2_valid_r || s2_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      pos_r      <= '0;
    end else if (s1_adv && dec.has_result) begin
      s2_valid_r <= 1'b1;
      pos_r      <= '0;
    end else if (s2_done) begin
      s2_valid_r <= 1'b0;
    end else if (out_load) begin
      pos_r <= pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && dec.has_result) begin
      s2_grp_r  <= dec.grp;
      s2_byte_r <= dec.echo_byte;
      s2_len_r  <= LEN_W'(fill_r);
      s2_rdok_r <= rd_ok;
    end
  end

  // The result at the current position of the group.
  always_comb begin
    res      = '0;
    res.kind = cle_pkg::KIND_ECHO;
    case (s2_grp_r)
      cle_pkg::GRP_CR_ECHO: begin
        case (pos_r)
          2'd0: res.data_byte = cle_pkg::CH_CR;
          2'd1: res.data_byte = cle_pkg::CH_LF;
          default: begin
            res.kind        = cle_pkg::KIND_DONE;
            res.line_length = s2_len_r;
            res.last        = 1'b1;
          end
        endcase
      end
      cle_pkg::GRP_CR: begin
        res.kind        = cle_pkg::KIND_DONE;
        res.line_length = s2_len_r;
        res.last        = 1'b1;
      end
      cle_pkg::GRP_BS: begin
        case (pos_r)
          2'd1:    res.data_byte = cle_pkg::CH_SPACE;
          2'd2: begin
            res.data_byte = cle_pkg::CH_BS;
            res.last      = 1'b1;
          end
          default: res.data_byte = cle_pkg::CH_BS;
        endcase
      end
      cle_pkg::GRP_READ: begin
        res.kind      = cle_pkg::KIND_READ;
        res.data_byte = s2_rdok_r ? ram_rdata : 8'd0;
        res.last      = 1'b1;
      end
      default: begin
        res.data_byte = s2_byte_r;
        res.last      = 1'b1;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/cle_checker.sv */
// Port-level checker for the console line editor, bound to the top level.
`include "console_line_editor_macros.svh"

module cle_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input cle_pkg::out_item_t out_data
);

  `CLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result item changed while stalled")

  `CLE_ASSERT_NOW(a_done_shape, out_valid && (out_data.kind == cle_pkg::KIND_DONE), out_data.last && (out_data.data_byte == 8'd0), "line complete item is malformed")

  `CLE_ASSERT_NOW(a_read_shape, out_valid && (out_data.kind == cle_pkg::KIND_READ), out_data.last && (out_data.line_length == '0), "read data item is malformed")

  `CLE_ASSERT_NEXT(a_cr_then_lf, out_valid && out_ready && (out_data.kind == cle_pkg::KIND_ECHO) && (out_data.data_byte == cle_pkg::CH_CR), out_valid && (out_data.kind == cle_pkg::KIND_ECHO) && (out_data.data_byte == cle_pkg::CH_LF), "echoed CR not followed by LF")

endmodule

bind console_line_editor cle_checker u_cle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
